// File: hw/rtl/tccpp_pkg.sv
`timescale 1ns / 1ps
package tccpp_pkg;

  // Default coordinate width of the pen and pixel arithmetic
  localparam int unsigned COORD_BITS_DEF = 16;

  // Field widths
  localparam int unsigned WidthBits  = 13;
  localparam int unsigned HeightBits = 13;
  localparam int unsigned RowBits    = 14;
  localparam int unsigned StartBits  = 12;
  localparam int unsigned OffsetBits = 26;
  localparam int unsigned PixBits    = 16;
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 14;

  // Input kinds carried on the slave tuser bit
  localparam logic ACT_BEGIN  = 1'b0;
  localparam logic ACT_SYMBOL = 1'b1;

  // Symbol codes
  localparam logic [7:0] SYM_MOVE = 8'h30;
  localparam logic [7:0] SYM_TURN = 8'h31;

  // Register indexes
  localparam logic [CfgAddrBits-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CfgAddrBits-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CfgAddrBits-1:0] CFG_ROW_BYTES    = 3'd2;
  localparam logic [CfgAddrBits-1:0] CFG_START_X      = 3'd3;
  localparam logic [CfgAddrBits-1:0] CFG_START_Y      = 3'd4;

  // Register reset values
  localparam logic [WidthBits-1:0]  RST_IMAGE_WIDTH  = 13'd1000;
  localparam logic [HeightBits-1:0] RST_IMAGE_HEIGHT = 13'd2400;
  localparam logic [RowBits-1:0]    RST_ROW_BYTES    = 14'd3000;
  localparam logic [StartBits-1:0]  RST_START_X      = 12'd200;
  localparam logic [StartBits-1:0]  RST_START_Y      = 12'd1200;

  // Headings and pixel index limits
  localparam logic [2:0] HEAD_FIRST = 3'd0;
  localparam logic [2:0] HEAD_LAST  = 3'd5;
  localparam logic [2:0] IDX_FIRST  = 3'd0;
  localparam logic [2:0] BEGIN_LAST = 3'd1;
  localparam logic [2:0] STAMP_LAST = 3'd7;

  typedef struct packed {
    logic [WidthBits-1:0]  image_width;
    logic [HeightBits-1:0] image_height;
    logic [RowBits-1:0]    row_bytes;
  } cfg_t;

  typedef struct packed {
    logic                  off_image;
    logic [OffsetBits-1:0] byte_offset;
  } pix_addr_t;

  // Pen step per heading
  function automatic logic signed [3:0] step_dx(input logic [2:0] h);
    logic signed [3:0] d;
    case (h)
      3'd0:    d = 4'sd6;
      3'd1:    d = 4'sd3;
      3'd2:    d = -4'sd3;
      3'd3:    d = -4'sd6;
      3'd4:    d = -4'sd3;
      3'd5:    d = 4'sd3;
      default: d = 4'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [3:0] step_dy(input logic [2:0] h);
    logic signed [3:0] d;
    case (h)
      3'd0:    d = 4'sd0;
      3'd1:    d = 4'sd3;
      3'd2:    d = 4'sd3;
      3'd3:    d = 4'sd0;
      3'd4:    d = -4'sd3;
      3'd5:    d = -4'sd3;
      default: d = 4'sd0;
    endcase
    return d;
  endfunction

  // Stamp offsets around the new pen position
  function automatic logic signed [3:0] stamp_dx(input logic [2:0] k);
    logic signed [3:0] d;
    case (k)
      3'd0:    d = 4'sd0;
      3'd1:    d = 4'sd1;
      3'd2:    d = 4'sd2;
      3'd3:    d = 4'sd3;
      3'd4:    d = 4'sd1;
      3'd5:    d = 4'sd2;
      3'd6:    d = 4'sd1;
      3'd7:    d = 4'sd2;
      default: d = 4'sd0;
    endcase
    return d;
  endfunction

  function automatic logic signed [3:0] stamp_dy(input logic [2:0] k);
    logic signed [3:0] d;
    case (k)
      3'd4, 3'd5: d = 4'sd1;
      3'd6, 3'd7: d = -4'sd1;
      default:    d = 4'sd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/tccpp_pix.sv
`timescale 1ns / 1ps
// Bounds check and bottom-up bitmap byte offset of one pixel
module tccpp_pix #(
  parameter int unsigned CoordBits = tccpp_pkg::COORD_BITS_DEF
) (
  input  logic [CoordBits-1:0] x_i,
  input  logic [CoordBits-1:0] y_i,
  input  tccpp_pkg::cfg_t      cfg_i,
  output tccpp_pkg::pix_addr_t addr_o
);

  logic                                  x_ge;
  logic                                  y_ge;
  logic                                  off;
  logic [tccpp_pkg::WidthBits-1:0]       x_lo;
  logic [tccpp_pkg::HeightBits-1:0]      y_lo;
  logic [tccpp_pkg::HeightBits-1:0]      row;
  logic [tccpp_pkg::HeightBits+tccpp_pkg::RowBits-1:0] prod;
  logic [tccpp_pkg::WidthBits+1:0]       x3;
  logic [tccpp_pkg::OffsetBits-1:0]      sum;

  // Flag pixels left of, below, or beyond the image
  assign x_ge = x_i >= CoordBits'(cfg_i.image_width);
  assign y_ge = y_i >= CoordBits'(cfg_i.image_height);
  assign off  = x_i[CoordBits-1] | y_i[CoordBits-1] | x_ge | y_ge;

  // On the image both coordinates fit the register widths
  assign x_lo = x_i[tccpp_pkg::WidthBits-1:0];
  assign y_lo = y_i[tccpp_pkg::HeightBits-1:0];
  assign row  = cfg_i.image_height - tccpp_pkg::HeightBits'(1) - y_lo;
  assign prod = row * cfg_i.row_bytes;
  assign x3   = (tccpp_pkg::WidthBits+2)'({x_lo, 1'b0}) + (tccpp_pkg::WidthBits+2)'(x_lo);
  assign sum  = prod[tccpp_pkg::OffsetBits-1:0] + tccpp_pkg::OffsetBits'(x3);

  assign addr_o.off_image   = off;
  assign addr_o.byte_offset = off ? '0 : sum;

endmodule

// File: hw/rtl/turtle_chain_code_pixel_plotter.sv
`timescale 1ns / 1ps
// Turtle plotter: a begin item puts the pen at the start point and gives two
// pixels, a '0' symbol steps the pen along its heading and gives an 8-pixel
// stamp, a '1' symbol turns the heading; each pixel leaves with its bitmap
// byte offset and an off-image flag. The result port carries one pixel per
// cycle unless m_axis_tready stalls it; a turn or other symbol gives no pixel.
// The pen updates as an item is taken; the next item is taken in the cycle
// the last pixel of the current one moves into the output register.
module turtle_chain_code_pixel_plotter #(
  parameter int unsigned CoordBits = tccpp_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tccpp_pkg::CfgAddrBits-1:0]   cfg_addr_i,
  input  logic [tccpp_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic        s_axis_tuser,   // [0] action
  // pixel results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [15:0] pixel_x, [31:16] pixel_y,
                                      // [57:32] byte_offset, rest zero
  output logic        m_axis_tuser,   // [0] off_image
  output logic        m_axis_tlast    // last pixel of the item
);

  // Configuration registers
  logic [tccpp_pkg::WidthBits-1:0]  image_width_q;
  logic [tccpp_pkg::HeightBits-1:0] image_height_q;
  logic [tccpp_pkg::RowBits-1:0]    row_bytes_q;
  logic [tccpp_pkg::StartBits-1:0]  start_x_q;
  logic [tccpp_pkg::StartBits-1:0]  start_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= tccpp_pkg::RST_IMAGE_WIDTH;
      image_height_q <= tccpp_pkg::RST_IMAGE_HEIGHT;
      row_bytes_q    <= tccpp_pkg::RST_ROW_BYTES;
      start_x_q      <= tccpp_pkg::RST_START_X;
      start_y_q      <= tccpp_pkg::RST_START_Y;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tccpp_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[tccpp_pkg::WidthBits-1:0];
        tccpp_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[tccpp_pkg::HeightBits-1:0];
        tccpp_pkg::CFG_ROW_BYTES:    row_bytes_q    <= cfg_wdata_i;
        tccpp_pkg::CFG_START_X:      start_x_q      <= cfg_wdata_i[tccpp_pkg::StartBits-1:0];
        tccpp_pkg::CFG_START_Y:      start_y_q      <= cfg_wdata_i[tccpp_pkg::StartBits-1:0];
        default: ;
      endcase
    end
  end

  // Pen state and current job
  logic [CoordBits-1:0] pen_x_q, pen_x_d;
  logic [CoordBits-1:0] pen_y_q, pen_y_d;
  logic [2:0]           heading_q, heading_d;
  logic                 job_valid_q, job_valid_d;
  logic                 job_move_q, job_move_d;
  logic [2:0]           job_idx_q, job_idx_d;
  logic [CoordBits-1:0] job_x_q, job_x_d;
  logic [CoordBits-1:0] job_y_q, job_y_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [tccpp_pkg::PixBits-1:0]    out_x_q, out_y_q;
  logic [tccpp_pkg::OffsetBits-1:0] out_ofs_q;
  logic                 out_off_q, out_last_q;

  logic                 in_fire;
  logic                 is_begin;
  logic                 is_move;
  logic                 is_turn;
  logic                 load_out;
  logic                 job_last;
  logic signed [3:0]    pix_dx, pix_dy;
  logic [CoordBits-1:0] pix_x, pix_y;
  logic [CoordBits-1:0] move_x, move_y;
  tccpp_pkg::cfg_t      cfg;
  tccpp_pkg::pix_addr_t pix_addr;

  // Decode the incoming item
  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign is_begin = s_axis_tuser == tccpp_pkg::ACT_BEGIN;
  assign is_move  = (s_axis_tuser == tccpp_pkg::ACT_SYMBOL) && (s_axis_tdata == tccpp_pkg::SYM_MOVE);
  assign is_turn  = (s_axis_tuser == tccpp_pkg::ACT_SYMBOL) && (s_axis_tdata == tccpp_pkg::SYM_TURN);

  // Pixel of the current job index
  assign job_last = job_move_q ? (job_idx_q == tccpp_pkg::STAMP_LAST)
                               : (job_idx_q == tccpp_pkg::BEGIN_LAST);
  assign pix_dx   = job_move_q ? tccpp_pkg::stamp_dx(job_idx_q) : 4'sd0;
  assign pix_dy   = job_move_q ? tccpp_pkg::stamp_dy(job_idx_q) : $signed({1'b0, job_idx_q});
  assign pix_x    = job_x_q + CoordBits'(pix_dx);
  assign pix_y    = job_y_q + CoordBits'(pix_dy);

  assign load_out      = job_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~job_valid_q | (load_out & job_last);

  assign cfg.image_width  = image_width_q;
  assign cfg.image_height = image_height_q;
  assign cfg.row_bytes    = row_bytes_q;

  tccpp_pix #(
    .CoordBits(CoordBits)
  ) u_pix (
    .x_i   (pix_x),
    .y_i   (pix_y),
    .cfg_i (cfg),
    .addr_o(pix_addr)
  );

  // Step the pen along its heading
  assign move_x = pen_x_q + CoordBits'(tccpp_pkg::step_dx(heading_q));
  assign move_y = pen_y_q + CoordBits'(tccpp_pkg::step_dy(heading_q));

  // Update pen and job
  always_comb begin
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    heading_d   = heading_q;
    job_valid_d = job_valid_q;
    job_move_d  = job_move_q;
    job_idx_d   = job_idx_q;
    job_x_d     = job_x_q;
    job_y_d     = job_y_q;

    // advance or retire the job as its pixel moves out
    if (load_out) begin
      if (job_last) begin
        job_valid_d = 1'b0;
      end else begin
        job_idx_d = job_idx_q + 3'd1;
      end
    end

    if (in_fire) begin
      if (is_begin) begin
        pen_x_d     = CoordBits'(start_x_q);
        pen_y_d     = CoordBits'(start_y_q);
        heading_d   = tccpp_pkg::HEAD_FIRST;
        job_valid_d = 1'b1;
        job_move_d  = 1'b0;
        job_idx_d   = tccpp_pkg::IDX_FIRST;
        job_x_d     = CoordBits'(start_x_q);
        job_y_d     = CoordBits'(start_y_q);
      end else if (is_move) begin
        pen_x_d     = move_x;
        pen_y_d     = move_y;
        job_valid_d = 1'b1;
        job_move_d  = 1'b1;
        job_idx_d   = tccpp_pkg::IDX_FIRST;
        job_x_d     = move_x;
        job_y_d     = move_y;
      end else if (is_turn) begin
        heading_d = (heading_q == tccpp_pkg::HEAD_LAST) ? tccpp_pkg::HEAD_FIRST
                                                         : heading_q + 3'd1;
      end
    end
  end

  // Output valid: load a pixel, or drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      heading_q   <= tccpp_pkg::HEAD_FIRST;
      job_valid_q <= 1'b0;
      job_move_q  <= 1'b0;
      job_idx_q   <= tccpp_pkg::IDX_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      heading_q   <= heading_d;
      job_valid_q <= job_valid_d;
      job_move_q  <= job_move_d;
      job_idx_q   <= job_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job coordinates and output payload
  always_ff @(posedge clk_i) begin
    job_x_q <= job_x_d;
    job_y_q <= job_y_d;
    if (load_out) begin
      out_x_q    <= tccpp_pkg::PixBits'(pix_x);
      out_y_q    <= tccpp_pkg::PixBits'(pix_y);
      out_ofs_q  <= pix_addr.byte_offset;
      out_off_q  <= pix_addr.off_image;
      out_last_q <= job_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_ofs_q, out_y_q, out_x_q};
  assign m_axis_tuser  = out_off_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hw/rtl/tccpp_checker.sv
`timescale 1ns / 1ps
module tccpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled pixel holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled pixel changed");

  // An off-image pixel carries a zero offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[57:32] == 26'd0)
    else $error("off-image pixel with nonzero offset");

  // An on-image pixel has nonnegative coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !m_axis_tdata[15] && !m_axis_tdata[31])
    else $error("on-image pixel with negative coordinate");

  // Pixels of one item follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside an item's pixels");

  // No new item while a pixel run is still open and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !(s_axis_tvalid && s_axis_tready))
    else $error("item taken during an open run");

endmodule

bind turtle_chain_code_pixel_plotter tccpp_checker u_tccpp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
